FILE: rtl/pswrl_pkg.sv
// Shared types and constants for the per-slot fixed-window rate limiter.
package pswrl_pkg;

    localparam int SLOT_W  = 6;
    localparam int FUNC_W  = 2;
    localparam int DATA_W  = 32;
    localparam int WAIT_W  = 10;
    localparam int QUOTA_W = 31;
    localparam int TOTAL_W = 64;

    typedef enum logic [FUNC_W-1:0] {
        FN_REQUEST     = 2'd0,
        FN_SET_RATE    = 2'd1,
        FN_DISABLE_ALL = 2'd2,
        FN_READ_STATS  = 2'd3
    } t_func;

    localparam logic [WAIT_W-1:0] TPW_RESET = 10'd100;

    typedef struct packed {
        logic [DATA_W-1:0]  rate;
        logic [DATA_W-1:0]  wstart;
        logic [TOTAL_W-1:0] total;
        logic [DATA_W-1:0]  last_rem;
        logic [WAIT_W-1:0]  last_pause;
    } t_stats;

    localparam t_stats STATS_RESET = '{
        rate:       32'hFFFF_FFFF,
        wstart:     '0,
        total:      '0,
        last_rem:   '0,
        last_pause: '0
    };

    typedef struct packed {
        logic accept;
        logic win;
        logic sweep;
        logic sweep_init;
        logic finish;
    } t_cmd;

endpackage

FILE: rtl/pswrl_ram.sv
// Generic simple dual-port RAM with registered read.
module pswrl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/pswrl_ctrl.sv
// Controller state machine: request sequencing, init pass and disable sweep.
module pswrl_ctrl #(
    parameter int SLOTS = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [pswrl_pkg::FUNC_W-1:0] i_func,
    output logic                       o_busy,
    output pswrl_pkg::t_cmd            o_cmd,
    output logic [$clog2(SLOTS)-1:0]   o_sweep_addr
);
    import pswrl_pkg::*;

    localparam int AW = $clog2(SLOTS);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_WIN,
        S_SWEEP,
        S_GRANT
    } t_state;

    t_state        r_state;
    logic [AW-1:0] r_cnt;
    logic          r_dis;
    logic          w_last;

    assign w_last = (r_cnt == AW'(SLOTS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_cnt   <= '0;
            r_dis   <= 1'b0;
        end else begin
            unique case (r_state)
                S_INIT: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (w_last) begin
                        r_cnt   <= '0;
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_start) begin
                        r_dis   <= (i_func == FN_DISABLE_ALL);
                        r_state <= S_WIN;
                    end
                end
                S_WIN: begin
                    r_state <= r_dis ? S_SWEEP : S_GRANT;
                end
                S_SWEEP: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (w_last) begin
                        r_cnt   <= '0;
                        r_state <= S_GRANT;
                    end
                end
                S_GRANT: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_INIT;
                end
            endcase
        end
    end

    always_comb begin
        o_cmd.accept     = (r_state == S_IDLE) && i_start;
        o_cmd.win        = (r_state == S_WIN);
        o_cmd.sweep      = (r_state == S_INIT) || (r_state == S_SWEEP);
        o_cmd.sweep_init = (r_state == S_INIT);
        o_cmd.finish     = (r_state == S_GRANT);
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_sweep_addr = r_cnt;

`ifndef NO_ASSERTIONS
    a_sweep_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.sweep |-> (r_cnt <= AW'(SLOTS - 1)))
        else $error("sweep address beyond table");
    a_finish_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> !o_cmd.finish && !o_busy)
        else $error("finish not followed by idle");
    a_accept_win: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> o_cmd.win)
        else $error("accepted request not evaluated");
`endif

endmodule

FILE: rtl/pswrl_dp.sv
// Datapath: slot tables, window and grant arithmetic, result registers.
module pswrl_dp #(
    parameter int SLOTS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pswrl_pkg::t_cmd                     i_cmd,
    input  logic [$clog2(SLOTS)-1:0]            i_sweep_addr,
    input  logic                                i_cfg_we,
    input  logic [pswrl_pkg::WAIT_W-1:0]        i_cfg_wdata,
    input  logic [pswrl_pkg::FUNC_W-1:0]        i_func,
    input  logic [pswrl_pkg::SLOT_W-1:0]        i_slot,
    input  logic [pswrl_pkg::DATA_W-1:0]        i_amount,
    input  logic signed [pswrl_pkg::DATA_W-1:0] i_rate,
    input  logic [pswrl_pkg::DATA_W-1:0]        i_now,
    output logic                                o_valid,
    output logic [pswrl_pkg::DATA_W-1:0]        o_granted,
    output logic [pswrl_pkg::DATA_W-1:0]        o_remaining,
    output logic [pswrl_pkg::WAIT_W-1:0]        o_wait_ticks,
    output logic                                o_limited,
    output logic signed [pswrl_pkg::DATA_W-1:0] o_rate_out,
    output logic [pswrl_pkg::QUOTA_W-1:0]       o_quota_out,
    output logic [pswrl_pkg::TOTAL_W-1:0]       o_granted_total_out,
    output logic [pswrl_pkg::DATA_W-1:0]        o_last_remaining_out,
    output logic [pswrl_pkg::WAIT_W-1:0]        o_last_pause_out
);
    import pswrl_pkg::*;

    localparam int AW = $clog2(SLOTS);
    localparam int CW = ((AW > SLOT_W) ? AW : SLOT_W) + 1;
    localparam int SW = $bits(t_stats);

    logic [WAIT_W-1:0]  r_tpw;
    t_func              r_func;
    logic               r_ok;
    logic [AW-1:0]      r_addr;
    logic [DATA_W-1:0]  r_amount;
    logic [DATA_W-1:0]  r_rate;
    logic [DATA_W-1:0]  r_now;
    logic [QUOTA_W-1:0] r_q;
    t_stats             r_st;
    logic [WAIT_W-1:0]  r_pause;
    logic               r_valid;

    logic [CW-1:0]      w_slot_ext;
    logic               w_slot_ok;
    logic [AW-1:0]      w_rd_addr;
    logic [QUOTA_W-1:0] w_q_rd;
    logic [SW-1:0]      w_st_raw;
    t_stats             w_st_rd;

    logic [WAIT_W-1:0]  w_win;
    logic [DATA_W-1:0]  w_diff;
    logic               w_restart;
    logic               w_refill;
    logic [WAIT_W-1:0]  w_pause;
    t_stats             w_st_win;

    logic [DATA_W-1:0]  w_g;
    logic [DATA_W-1:0]  w_d;
    logic [DATA_W-1:0]  n_granted;
    logic [DATA_W-1:0]  n_rem;
    logic [WAIT_W-1:0]  n_wait;
    logic [QUOTA_W-1:0] n_q;
    t_stats             n_st;
    logic               w_wr;

    logic               w_st_we;
    logic [AW-1:0]      w_waddr;
    t_stats             w_st_wdata;
    logic               w_q_we;
    logic [QUOTA_W-1:0] w_q_wdata;

    assign w_slot_ext = CW'(i_slot);
    assign w_slot_ok  = (w_slot_ext < CW'(SLOTS));
    assign w_rd_addr  = w_slot_ext[AW-1:0];
    assign w_st_rd    = t_stats'(w_st_raw);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpw <= TPW_RESET;
        end else if (i_cfg_we) begin
            r_tpw <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_func   <= t_func'(i_func);
            r_ok     <= w_slot_ok;
            r_addr   <= w_rd_addr;
            r_amount <= i_amount;
            r_rate   <= i_rate;
            r_now    <= i_now;
        end
    end

    always_comb begin
        w_win     = (r_tpw == '0) ? WAIT_W'(1) : r_tpw;
        w_diff    = r_now - w_st_rd.wstart;
        w_restart = (r_now < w_st_rd.wstart) || (w_diff >= DATA_W'(w_win));
        w_refill  = (r_func == FN_REQUEST) && r_ok && !w_st_rd.rate[DATA_W-1] && w_restart;
        w_pause   = w_restart ? w_win : (w_win - w_diff[WAIT_W-1:0]);
        w_st_win  = w_st_rd;
        if (w_refill) begin
            w_st_win.wstart = r_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.win) begin
            r_q     <= w_refill ? w_st_rd.rate[QUOTA_W-1:0] : w_q_rd;
            r_st    <= w_st_win;
            r_pause <= w_pause;
        end
    end

    always_comb begin
        w_g       = (r_amount < DATA_W'(r_q)) ? r_amount : DATA_W'(r_q);
        w_d       = r_amount - w_g;
        n_granted = '0;
        n_rem     = '0;
        n_wait    = '0;
        n_q       = r_q;
        n_st      = r_st;
        w_wr      = 1'b0;
        unique case (r_func)
            FN_REQUEST: begin
                if (!r_ok || r_st.rate[DATA_W-1]) begin
                    n_granted = r_amount;
                end else begin
                    w_wr = 1'b1;
                    if (r_amount == '0) begin
                        n_st.last_rem = '0;
                    end else if (r_q == '0) begin
                        n_rem  = r_amount;
                        n_wait = r_pause;
                    end else begin
                        n_granted     = w_g;
                        n_rem         = w_d;
                        n_q           = r_q - w_g[QUOTA_W-1:0];
                        n_st.total    = r_st.total + TOTAL_W'(w_g);
                        n_st.last_rem = w_d;
                        if (w_d != '0) begin
                            n_st.last_pause = r_pause;
                            n_wait          = r_pause;
                        end
                    end
                end
            end
            FN_SET_RATE: begin
                if (r_ok) begin
                    w_wr       = 1'b1;
                    n_st.rate  = r_rate;
                    n_st.total = '0;
                end
            end
            FN_DISABLE_ALL: begin
                n_st = STATS_RESET;
            end
            FN_READ_STATS: begin
                n_st = r_st;
            end
        endcase
    end

    assign w_st_we    = i_cmd.sweep || (i_cmd.finish && w_wr);
    assign w_q_we     = i_cmd.sweep_init || (i_cmd.finish && w_wr);
    assign w_waddr    = i_cmd.sweep ? i_sweep_addr : r_addr;
    assign w_st_wdata = i_cmd.sweep ? STATS_RESET : n_st;
    assign w_q_wdata  = i_cmd.sweep_init ? '0 : n_q;

    pswrl_ram #(
        .WIDTH (QUOTA_W),
        .DEPTH (SLOTS)
    ) u_quota_ram (
        .i_clk   (i_clk),
        .i_we    (w_q_we),
        .i_waddr (w_waddr),
        .i_wdata (w_q_wdata),
        .i_re    (i_cmd.accept),
        .i_raddr (w_rd_addr),
        .o_rdata (w_q_rd)
    );

    pswrl_ram #(
        .WIDTH (SW),
        .DEPTH (SLOTS)
    ) u_stats_ram (
        .i_clk   (i_clk),
        .i_we    (w_st_we),
        .i_waddr (w_waddr),
        .i_wdata (w_st_wdata),
        .i_re    (i_cmd.accept),
        .i_raddr (w_rd_addr),
        .o_rdata (w_st_raw)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_granted    <= n_granted;
            o_remaining  <= n_rem;
            o_wait_ticks <= n_wait;
            if (r_ok) begin
                o_limited            <= !n_st.rate[DATA_W-1];
                o_rate_out           <= n_st.rate;
                o_quota_out          <= n_q;
                o_granted_total_out  <= n_st.total;
                o_last_remaining_out <= n_st.last_rem;
                o_last_pause_out     <= n_st.last_pause;
            end else begin
                o_limited            <= 1'b0;
                o_rate_out           <= '1;
                o_quota_out          <= '0;
                o_granted_total_out  <= '0;
                o_last_remaining_out <= '0;
                o_last_pause_out     <= '0;
            end
        end
    end

    assign o_valid = r_valid;

endmodule

FILE: rtl/per_slot_fixed_window_rate_limiter.sv
// Top level of the per-slot fixed-window rate limiter.
// Usage:
//   Raise start with func, slot, amount, rate and now; the request is taken
//   at a clock edge where start is high and busy is low.
//   func selects request, set_rate, disable_all or read_stats.
//   Each request yields one result, shown for one cycle with o_valid high.
//   Request, set_rate and read_stats: the slot's entry in the quota and
//   statistics RAMs is read, checked against the window, then granted and
//   written back where changed; busy stays high until the grant step ends.
//   Disable_all: after the window check the statistics RAM is rewritten
//   one slot per cycle, and then the result is given.
//   Configuration: i_cfg_we writes ticks_per_window from i_cfg_wdata; write
//   it only while idle.
//   Reset: synchronous, active low. After reset an init pass over all SLOTS
//   entries clears both RAMs with busy high; ticks_per_window returns to 100.
//   The receiver cannot stall: each result is held for exactly one cycle.
module per_slot_fixed_window_rate_limiter #(
    parameter int SLOTS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_cfg_we,
    input  logic [pswrl_pkg::WAIT_W-1:0]        i_cfg_wdata,
    input  logic [pswrl_pkg::FUNC_W-1:0]        i_func,
    input  logic [pswrl_pkg::SLOT_W-1:0]        i_slot,
    input  logic [pswrl_pkg::DATA_W-1:0]        i_amount,
    input  logic signed [pswrl_pkg::DATA_W-1:0] i_rate,
    input  logic [pswrl_pkg::DATA_W-1:0]        i_now,
    output logic                                o_valid,
    output logic [pswrl_pkg::DATA_W-1:0]        o_granted,
    output logic [pswrl_pkg::DATA_W-1:0]        o_remaining,
    output logic [pswrl_pkg::WAIT_W-1:0]        o_wait_ticks,
    output logic                                o_limited,
    output logic signed [pswrl_pkg::DATA_W-1:0] o_rate_out,
    output logic [pswrl_pkg::QUOTA_W-1:0]       o_quota_out,
    output logic [pswrl_pkg::TOTAL_W-1:0]       o_granted_total_out,
    output logic [pswrl_pkg::DATA_W-1:0]        o_last_remaining_out,
    output logic [pswrl_pkg::WAIT_W-1:0]        o_last_pause_out
);
    import pswrl_pkg::*;

    t_cmd                     w_cmd;
    logic [$clog2(SLOTS)-1:0] w_sweep_addr;

    pswrl_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_func       (i_func),
        .o_busy       (busy),
        .o_cmd        (w_cmd),
        .o_sweep_addr (w_sweep_addr)
    );

    pswrl_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (w_cmd),
        .i_sweep_addr         (w_sweep_addr),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_wdata          (i_cfg_wdata),
        .i_func               (i_func),
        .i_slot               (i_slot),
        .i_amount             (i_amount),
        .i_rate               (i_rate),
        .i_now                (i_now),
        .o_valid              (o_valid),
        .o_granted            (o_granted),
        .o_remaining          (o_remaining),
        .o_wait_ticks         (o_wait_ticks),
        .o_limited            (o_limited),
        .o_rate_out           (o_rate_out),
        .o_quota_out          (o_quota_out),
        .o_granted_total_out  (o_granted_total_out),
        .o_last_remaining_out (o_last_remaining_out),
        .o_last_pause_out     (o_last_pause_out)
    );

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after request");
    a_wait_needs_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_wait_ticks != '0)) |-> (o_remaining != '0))
        else $error("wait issued with nothing remaining");
    a_unlimited_no_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_limited) |-> (o_wait_ticks == '0) && (o_remaining == '0))
        else $error("unlimited slot produced a wait");
`endif

endmodule

FILE: bench/per_slot_fixed_window_rate_limiter_tb.sv
// Self-checking testbench for the per-slot fixed-window rate limiter.
module per_slot_fixed_window_rate_limiter_tb;
    import pswrl_pkg::*;

    localparam int NSLOT = 64;
    localparam int PHASE_ITEMS = 325;

    typedef struct {
        logic [DATA_W-1:0]  granted;
        logic [DATA_W-1:0]  remaining;
        logic [WAIT_W-1:0]  wait_ticks;
        logic               limited;
        logic [DATA_W-1:0]  rate_out;
        logic [QUOTA_W-1:0] quota_out;
        logic [TOTAL_W-1:0] total_out;
        logic [DATA_W-1:0]  last_rem_out;
        logic [WAIT_W-1:0]  last_pause_out;
    } t_reply;

    class slot_budget_board;
        logic [DATA_W-1:0]  budget_rate [NSLOT];
        logic [QUOTA_W-1:0] budget_quota[NSLOT];
        logic [DATA_W-1:0]  win_begin   [NSLOT];
        logic [TOTAL_W-1:0] sum_granted [NSLOT];
        logic [DATA_W-1:0]  rem_last    [NSLOT];
        logic [WAIT_W-1:0]  pause_last  [NSLOT];
        logic [WAIT_W-1:0]  win_len;
        t_reply             due_replies[$];
        int                 errors;

        function new();
            win_len = TPW_RESET;
            errors  = 0;
            for (int i = 0; i < NSLOT; i++) begin
                clear_slot(i);
                budget_quota[i] = '0;
            end
        endfunction

        function void clear_slot(int i);
            budget_rate[i] = '1;
            win_begin[i]   = '0;
            sum_granted[i] = '0;
            rem_last[i]    = '0;
            pause_last[i]  = '0;
        endfunction

        function void set_window(logic [WAIT_W-1:0] len);
            win_len = len;
        endfunction

        function int pending();
            return due_replies.size();
        endfunction

        function void take_request(t_func f, logic [SLOT_W-1:0] s, logic [DATA_W-1:0] amount,
                                   logic [DATA_W-1:0] rate, logic [DATA_W-1:0] now);
            t_reply            r;
            logic [DATA_W-1:0] win;
            logic [DATA_W-1:0] pause;
            logic [DATA_W-1:0] quota;
            logic [DATA_W-1:0] grant;
            r = '{default: '0};
            case (f)
                FN_REQUEST: begin
                    if (budget_rate[s][DATA_W-1]) begin
                        r.granted = amount;
                    end else begin
                        win = (win_len == 0) ? 32'd1 : {22'd0, win_len};
                        if (now < win_begin[s] || now - win_begin[s] >= win) begin
                            win_begin[s]    = now;
                            budget_quota[s] = budget_rate[s][QUOTA_W-1:0];
                        end
                        pause = win - (now - win_begin[s]);
                        quota = {1'b0, budget_quota[s]};
                        if (amount == 0) begin
                            rem_last[s] = '0;
                        end else if (quota == 0) begin
                            r.remaining  = amount;
                            r.wait_ticks = pause[WAIT_W-1:0];
                        end else begin
                            grant           = (amount < quota) ? amount : quota;
                            r.granted       = grant;
                            r.remaining     = amount - grant;
                            budget_quota[s] = QUOTA_W'(quota - grant);
                            sum_granted[s]  = sum_granted[s] + grant;
                            rem_last[s]     = r.remaining;
                            if (r.remaining != 0) begin
                                pause_last[s] = pause[WAIT_W-1:0];
                                r.wait_ticks  = pause[WAIT_W-1:0];
                            end
                        end
                    end
                end
                FN_SET_RATE: begin
                    budget_rate[s] = rate;
                    sum_granted[s] = '0;
                end
                FN_DISABLE_ALL: begin
                    for (int i = 0; i < NSLOT; i++) clear_slot(i);
                end
                default: ;
            endcase
            r.limited        = !budget_rate[s][DATA_W-1];
            r.rate_out       = budget_rate[s];
            r.quota_out      = budget_quota[s];
            r.total_out      = sum_granted[s];
            r.last_rem_out   = rem_last[s];
            r.last_pause_out = pause_last[s];
            due_replies.push_back(r);
        endfunction

        function void check_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void match_result(t_reply got);
            t_reply want;
            if (due_replies.size() == 0) begin
                $display("%0t: result with no request outstanding", $time);
                errors++;
                return;
            end
            want = due_replies.pop_front();
            check_field("granted", want.granted, got.granted);
            check_field("remaining", want.remaining, got.remaining);
            check_field("wait_ticks", want.wait_ticks, got.wait_ticks);
            check_field("limited", want.limited, got.limited);
            check_field("rate_out", want.rate_out, got.rate_out);
            check_field("quota_out", want.quota_out, got.quota_out);
            check_field("granted_total_out", want.total_out, got.total_out);
            check_field("last_remaining_out", want.last_rem_out, got.last_rem_out);
            check_field("last_pause_out", want.last_pause_out, got.last_pause_out);
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 i_cfg_we = 1'b0;
    logic [WAIT_W-1:0]    i_cfg_wdata = '0;
    logic [FUNC_W-1:0]    i_func = '0;
    logic [SLOT_W-1:0]    i_slot = '0;
    logic [DATA_W-1:0]    i_amount = '0;
    logic [DATA_W-1:0]    i_rate = '0;
    logic [DATA_W-1:0]    i_now = '0;
    logic                 o_valid;
    logic [DATA_W-1:0]    o_granted;
    logic [DATA_W-1:0]    o_remaining;
    logic [WAIT_W-1:0]    o_wait_ticks;
    logic                 o_limited;
    logic [DATA_W-1:0]    o_rate_out;
    logic [QUOTA_W-1:0]   o_quota_out;
    logic [TOTAL_W-1:0]   o_granted_total_out;
    logic [DATA_W-1:0]    o_last_remaining_out;
    logic [WAIT_W-1:0]    o_last_pause_out;

    slot_budget_board board = new();
    logic [DATA_W-1:0] tick = '0;
    logic [WAIT_W-1:0] cur_len = TPW_RESET;

    per_slot_fixed_window_rate_limiter #(.SLOTS(NSLOT)) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_func(i_func),
        .i_slot(i_slot),
        .i_amount(i_amount),
        .i_rate(i_rate),
        .i_now(i_now),
        .o_valid(o_valid),
        .o_granted(o_granted),
        .o_remaining(o_remaining),
        .o_wait_ticks(o_wait_ticks),
        .o_limited(o_limited),
        .o_rate_out(o_rate_out),
        .o_quota_out(o_quota_out),
        .o_granted_total_out(o_granted_total_out),
        .o_last_remaining_out(o_last_remaining_out),
        .o_last_pause_out(o_last_pause_out)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            board.match_result('{o_granted, o_remaining, o_wait_ticks, o_limited, o_rate_out,
                                 o_quota_out, o_granted_total_out, o_last_remaining_out,
                                 o_last_pause_out});
        if (i_rst_n && start && !busy)
            board.take_request(t_func'(i_func), i_slot, i_amount, i_rate, i_now);
    end

    task automatic issue(input t_func f, input logic [SLOT_W-1:0] s,
                         input logic [DATA_W-1:0] amt, input logic [DATA_W-1:0] rt,
                         input logic [DATA_W-1:0] nw);
        start    <= 1'b1;
        i_func   <= f;
        i_slot   <= s;
        i_amount <= amt;
        i_rate   <= rt;
        i_now    <= nw;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic hold_off(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        do @(posedge i_clk); while (board.pending() != 0);
    endtask

    task automatic set_window_len(input logic [WAIT_W-1:0] len);
        drain_results();
        while (busy) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= len;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        board.set_window(len);
        cur_len = len;
    endtask

    task automatic random_item();
        int w;
        int r;
        t_func f;
        logic [SLOT_W-1:0] s;
        logic [DATA_W-1:0] amt;
        logic [DATA_W-1:0] rt;
        w = (cur_len == 0) ? 1 : int'(cur_len);
        r = $urandom_range(0, 99);
        if (r < 80)
            tick = tick + $urandom_range(0, w / 4 + 1);
        else if (r < 88)
            tick = tick + $urandom_range(w, 3 * w + 2);
        else if (r < 94)
            tick = tick - $urandom_range(1, w + 1);
        else
            tick = $urandom();
        s = SLOT_W'(($urandom_range(0, 99) < 85) ? $urandom_range(0, 7)
                                                  : $urandom_range(0, NSLOT - 1));
        r = $urandom_range(0, 99);
        f = (r < 68) ? FN_REQUEST : (r < 83) ? FN_SET_RATE :
            (r < 97) ? FN_READ_STATS : FN_DISABLE_ALL;
        r = $urandom_range(0, 99);
        amt = (r < 8) ? 32'd0 : (r < 16) ? $urandom() : (r < 20) ? 32'hFFFF_FFFF :
              $urandom_range(1, 1500);
        r = $urandom_range(0, 99);
        rt = (r < 10) ? 32'hFFFF_FFFF : (r < 15) ? $urandom() : (r < 18) ? 32'h7FFF_FFFF :
             (r < 23) ? 32'd0 : $urandom_range(1, 2000);
        issue(f, s, amt, rt, tick);
    endtask

    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        logic [WAIT_W-1:0] lens[6];
        int idle_pct[6];
        lens     = '{10'd1, 10'd1000, 10'd100, 10'd1023, 10'd37, 10'd2};
        idle_pct = '{29, 29, 85, 85, 0, 0};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset state, unlimited slot, window refills, empty quota, time going back
        issue(FN_READ_STATS, 6'd0, 32'd0, 32'd0, 32'd0);
        issue(FN_REQUEST, 6'd0, 32'hFFFF_FFFF, 32'd0, 32'd10);
        issue(FN_SET_RATE, 6'd5, 32'd0, 32'd1000, 32'd0);
        issue(FN_REQUEST, 6'd5, 32'd0, 32'd0, 32'd50);
        issue(FN_REQUEST, 6'd5, 32'd300, 32'd0, 32'd50);
        issue(FN_REQUEST, 6'd5, 32'd300, 32'd0, 32'd100);
        issue(FN_REQUEST, 6'd5, 32'd800, 32'd0, 32'd120);
        issue(FN_REQUEST, 6'd5, 32'd10, 32'd0, 32'd130);
        issue(FN_REQUEST, 6'd5, 32'd0, 32'd0, 32'd140);
        issue(FN_REQUEST, 6'd5, 32'd40, 32'd0, 32'd20);
        issue(FN_READ_STATS, 6'd5, 32'd0, 32'd0, 32'd0);
        issue(FN_SET_RATE, 6'd63, 32'd0, 32'h7FFF_FFFF, 32'd0);
        issue(FN_REQUEST, 6'd63, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
        issue(FN_SET_RATE, 6'd1, 32'd0, 32'd0, 32'd0);
        issue(FN_REQUEST, 6'd1, 32'd5, 32'd0, 32'd200);
        issue(FN_SET_RATE, 6'd2, 32'd0, 32'h8000_0000, 32'd0);
        issue(FN_REQUEST, 6'd2, 32'd7, 32'd0, 32'd300);
        issue(FN_DISABLE_ALL, 6'd0, 32'd0, 32'd0, 32'd0);
        issue(FN_READ_STATS, 6'd63, 32'd0, 32'd0, 32'd0);
        issue(FN_SET_RATE, 6'd5, 32'd0, 32'd1, 32'd0);
        issue(FN_REQUEST, 6'd5, 32'd9, 32'd0, 32'd30);
        set_window_len(10'd0);
        issue(FN_SET_RATE, 6'd3, 32'd0, 32'd10, 32'd0);
        issue(FN_REQUEST, 6'd3, 32'd25, 32'd0, 32'd5);
        issue(FN_REQUEST, 6'd3, 32'd5, 32'd0, 32'd5);
        issue(FN_REQUEST, 6'd3, 32'd5, 32'd0, 32'd6);

        for (int p = 0; p < 6; p++) begin
            set_window_len(lens[p]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                random_item();
                if (n == PHASE_ITEMS / 2)
                    drain_results();
                else if ($urandom_range(0, 99) < idle_pct[p])
                    hold_off($urandom_range(1, 6));
                else if (idle_pct[p] == 0 && n % 40 == 39)
                    hold_off(1);
            end
        end

        drain_results();
        repeat (NSLOT + 8) @(posedge i_clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
